### src/imtag_pkg.sv
// Shared widths, register indexes and the configuration struct for the
// im2col tiled address generator. No dependencies.
package imtag_pkg;

   localparam int CH_W       = 10;
   localparam int KR_W       = 4;
   localparam int OR_W       = 9;
   localparam int HW_W       = 10;
   localparam int KH_W       = 4;
   localparam int PAD_W      = 3;
   localparam int STR_W      = 3;
   localparam int TGC_W      = 15;
   localparam int DEST_W     = 36;
   localparam int SRC_W      = 28;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 15;

   localparam int CHK_W  = 14;
   localparam int KRKW_W = 9;
   localparam int MROW_W = 18;
   localparam int MCOL_W = 20;
   localparam int POS_W  = 12;
   localparam int CHH_W  = 20;

   localparam int NUM_STAGES = 6;

   localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT      = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH       = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH   = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH      = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_PAD            = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_TILE_GRID_COLS = 3'd7;

   typedef struct packed {
      logic [HW_W-1:0]  in_height;
      logic [HW_W-1:0]  in_width;
      logic [KH_W-1:0]  kernel_height;
      logic [KH_W-1:0]  kernel_width;
      logic [HW_W-1:0]  out_width;
      logic [PAD_W-1:0] pad;
      logic [STR_W-1:0] stride;
      logic [TGC_W-1:0] tile_grid_cols;
   } cfg_type;

endpackage

### src/imtag_ifs.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on imtag_pkg.
interface imtag_req_if import imtag_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] channel;
   logic [KR_W-1:0] kern_row;
   logic [KR_W-1:0] kern_col;
   logic [OR_W-1:0] out_row;
   logic [OR_W-1:0] out_col;

   modport source (output valid, channel, kern_row, kern_col, out_row, out_col,
                   input ready);
   modport sink   (input valid, channel, kern_row, kern_col, out_row, out_col,
                   output ready);
endinterface

interface imtag_rsp_if import imtag_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DEST_W-1:0] dest_address;
   logic [SRC_W-1:0]  source_address;
   logic              is_padding;

   modport source (output valid, dest_address, source_address, is_padding,
                   input ready);
   modport sink   (input valid, dest_address, source_address, is_padding,
                   output ready);
endinterface

interface imtag_csr_if import imtag_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CFG_IDX_W-1:0]  index;
   logic [CFG_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/im2col_tiled_address_gen.sv
// im2col tiled address generator, top level.
// Six register stages lie between request accept and response valid.
// Throughput: one item per cycle unless output backpressure stalls; a stage
// advances when it is empty or the next one advances, so bubbles collapse then.
// Reset clears all stage valid bits and loads the register defaults.
// Depends on imtag_pkg, imtag_ifs, imtag_csr and imtag_divc.
module im2col_tiled_address_gen import imtag_pkg::*; #(
   parameter int CUBE_ROWS = 16,
   parameter int CUBE_COLS = 16
) (
   input  logic        clock,
   input  logic        reset,
   imtag_req_if.sink   req_ch,
   imtag_rsp_if.source rsp_ch,
   imtag_csr_if.sink   csr_ch
);

   localparam int RR_W  = $clog2(CUBE_ROWS);
   localparam int CR_W  = $clog2(CUBE_COLS);
   localparam int CUBE  = CUBE_ROWS * CUBE_COLS;
   localparam int REM_W = $clog2(CUBE);
   localparam int CB_W  = $clog2(CUBE + 1);

   cfg_type cfg;

   logic [NUM_STAGES-1:0] stage_valid_ff;
   logic [NUM_STAGES-1:0] stage_valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   imtag_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // stage control
   always_comb begin
      stage_en[NUM_STAGES-1] = !stage_valid_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
      stage_valid_in[0] = stage_en[0] ? req_ch.valid : stage_valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         stage_valid_in[k] = stage_en[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_ch.ready = stage_en[0];

   // stage 0: first products
   logic [CHK_W-1:0]  s0_chk_in,  s0_chk_ff;
   logic [KRKW_W-1:0] s0_krkw_in, s0_krkw_ff;
   logic [MCOL_W-1:0] s0_mcol_in, s0_mcol_ff;
   logic [POS_W-1:0]  s0_rpos_in, s0_rpos_ff;
   logic [POS_W-1:0]  s0_cpos_in, s0_cpos_ff;
   logic [CHH_W-1:0]  s0_chh_in,  s0_chh_ff;

   always_comb begin
      s0_chk_in  = CHK_W'(CHK_W'(req_ch.channel) * CHK_W'(cfg.kernel_height));
      s0_krkw_in = KRKW_W'(KRKW_W'(req_ch.kern_row) * KRKW_W'(cfg.kernel_width))
                 + KRKW_W'(req_ch.kern_col);
      s0_mcol_in = MCOL_W'(MCOL_W'(req_ch.out_row) * MCOL_W'(cfg.out_width))
                 + MCOL_W'(req_ch.out_col);
      s0_rpos_in = POS_W'(POS_W'(req_ch.out_row) * POS_W'(cfg.stride))
                 + POS_W'(req_ch.kern_row);
      s0_cpos_in = POS_W'(POS_W'(req_ch.out_col) * POS_W'(cfg.stride))
                 + POS_W'(req_ch.kern_col);
      s0_chh_in  = CHH_W'(CHH_W'(req_ch.channel) * CHH_W'(cfg.in_height));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_chk_ff  <= s0_chk_in;
         s0_krkw_ff <= s0_krkw_in;
         s0_mcol_ff <= s0_mcol_in;
         s0_rpos_ff <= s0_rpos_in;
         s0_cpos_ff <= s0_cpos_in;
         s0_chh_ff  <= s0_chh_in;
      end
   end

   // stage 1: matrix row, padding test, channel plane offset
   logic [MROW_W-1:0] s1_mrow_in, s1_mrow_ff;
   logic [HW_W-1:0]   s1_irow_in, s1_irow_ff;
   logic [HW_W-1:0]   s1_icol_in, s1_icol_ff;
   logic              s1_pad_in,  s1_pad_ff;
   logic [SRC_W-1:0]  s1_chhw_in, s1_chhw_ff;
   logic [POS_W-1:0]  row_d;
   logic [POS_W-1:0]  col_d;
   logic              row_ok;
   logic              col_ok;

   always_comb begin
      s1_mrow_in = MROW_W'(MROW_W'(s0_chk_ff) * MROW_W'(cfg.kernel_width))
                 + MROW_W'(s0_krkw_ff);
      row_d      = s0_rpos_ff - POS_W'(cfg.pad);
      col_d      = s0_cpos_ff - POS_W'(cfg.pad);
      row_ok     = (s0_rpos_ff >= POS_W'(cfg.pad)) && (row_d < POS_W'(cfg.in_height));
      col_ok     = (s0_cpos_ff >= POS_W'(cfg.pad)) && (col_d < POS_W'(cfg.in_width));
      s1_pad_in  = !(row_ok && col_ok);
      s1_irow_in = row_d[HW_W-1:0];
      s1_icol_in = col_d[HW_W-1:0];
      s1_chhw_in = SRC_W'(SRC_W'(s0_chh_ff) * SRC_W'(cfg.in_width));
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_mrow_ff <= s1_mrow_in;
         s1_irow_ff <= s1_irow_in;
         s1_icol_ff <= s1_icol_in;
         s1_pad_ff  <= s1_pad_in;
         s1_chhw_ff <= s1_chhw_in;
      end
   end

   // matrix column split: stages 1 and 2
   logic [MCOL_W-1:0] mcol_q;
   logic [CR_W-1:0]   mcol_r;

   imtag_divc #(.XW(MCOL_W), .DIV(CUBE_COLS)) u_div_col (
      .clock (clock),
      .en_a  (stage_en[1]),
      .en_b  (stage_en[2]),
      .x     (s0_mcol_ff),
      .q     (mcol_q),
      .r     (mcol_r)
   );

   // matrix row split: stages 2 and 3
   logic [MROW_W-1:0] mrow_q;
   logic [RR_W-1:0]   mrow_r;

   imtag_divc #(.XW(MROW_W), .DIV(CUBE_ROWS)) u_div_row (
      .clock (clock),
      .en_a  (stage_en[2]),
      .en_b  (stage_en[3]),
      .x     (s1_mrow_ff),
      .q     (mrow_q),
      .r     (mrow_r)
   );

   // stage 2: source address
   logic [SRC_W-1:0] s2_src_in, s2_src_ff;
   logic [SRC_W-1:0] src_sum;
   logic             s2_pad_ff;

   always_comb begin
      src_sum   = s1_chhw_ff + SRC_W'(SRC_W'(s1_irow_ff) * SRC_W'(cfg.in_width))
                + SRC_W'(s1_icol_ff);
      s2_src_in = s1_pad_ff ? '0 : src_sum;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_src_ff <= s2_src_in;
         s2_pad_ff <= s1_pad_ff;
      end
   end

   // stage 3: align column split with row split
   logic [MCOL_W-1:0] s3_mcolq_ff;
   logic [CR_W-1:0]   s3_mcolr_ff;
   logic [SRC_W-1:0]  s3_src_ff;
   logic              s3_pad_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_mcolq_ff <= mcol_q;
         s3_mcolr_ff <= mcol_r;
         s3_src_ff   <= s2_src_ff;
         s3_pad_ff   <= s2_pad_ff;
      end
   end

   // stage 4: tile index and offset inside the tile
   logic [DEST_W-1:0] s4_tile_in, s4_tile_ff;
   logic [REM_W-1:0]  s4_rem_in,  s4_rem_ff;
   logic [SRC_W-1:0]  s4_src_ff;
   logic              s4_pad_ff;

   always_comb begin
      s4_tile_in = DEST_W'(DEST_W'(mrow_q) * DEST_W'(cfg.tile_grid_cols))
                 + DEST_W'(s3_mcolq_ff);
      s4_rem_in  = REM_W'(REM_W'(mrow_r) * REM_W'(CUBE_COLS)) + REM_W'(s3_mcolr_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_tile_ff <= s4_tile_in;
         s4_rem_ff  <= s4_rem_in;
         s4_src_ff  <= s3_src_ff;
         s4_pad_ff  <= s3_pad_ff;
      end
   end

   // stage 5: output register
   logic [DEST_W-1:0] s5_dest_in, s5_dest_ff;
   logic [SRC_W-1:0]  s5_src_ff;
   logic              s5_pad_ff;

   always_comb begin
      s5_dest_in = DEST_W'(s4_tile_ff * CB_W'(CUBE)) + DEST_W'(s4_rem_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_dest_ff <= s5_dest_in;
         s5_src_ff  <= s4_src_ff;
         s5_pad_ff  <= s4_pad_ff;
      end
   end

   assign rsp_ch.valid          = stage_valid_ff[NUM_STAGES-1];
   assign rsp_ch.dest_address   = s5_dest_ff;
   assign rsp_ch.source_address = s5_src_ff;
   assign rsp_ch.is_padding     = s5_pad_ff;

`ifndef SYNTHESIS
   a_pad_zero_src: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_padding |-> rsp_ch.source_address == '0)
      else $error("padding item with nonzero source address");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> stage_valid_ff[0])
      else $error("accepted item did not enter the first stage");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[NUM_STAGES-2] && !stage_en[NUM_STAGES-1]
      |=> stage_valid_ff[NUM_STAGES-2])
      else $error("item dropped from a stalled stage");
`endif

endmodule

### src/imtag_csr.sv
// Configuration register file, written through the csr channel.
// Depends on imtag_pkg and imtag_csr_if.
module imtag_csr import imtag_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   imtag_csr_if.sink   csr_ch,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_IN_HEIGHT:      cfg_in.in_height      = csr_ch.data[HW_W-1:0];
            REG_IN_WIDTH:       cfg_in.in_width       = csr_ch.data[HW_W-1:0];
            REG_KERNEL_HEIGHT:  cfg_in.kernel_height  = csr_ch.data[KH_W-1:0];
            REG_KERNEL_WIDTH:   cfg_in.kernel_width   = csr_ch.data[KH_W-1:0];
            REG_OUT_WIDTH:      cfg_in.out_width      = csr_ch.data[HW_W-1:0];
            REG_PAD:            cfg_in.pad            = csr_ch.data[PAD_W-1:0];
            REG_STRIDE:         cfg_in.stride         = csr_ch.data[STR_W-1:0];
            REG_TILE_GRID_COLS: cfg_in.tile_grid_cols = csr_ch.data[TGC_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_height      <= HW_W'(1);
         cfg_ff.in_width       <= HW_W'(1);
         cfg_ff.kernel_height  <= KH_W'(1);
         cfg_ff.kernel_width   <= KH_W'(1);
         cfg_ff.out_width      <= HW_W'(1);
         cfg_ff.pad            <= '0;
         cfg_ff.stride         <= STR_W'(1);
         cfg_ff.tile_grid_cols <= TGC_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/imtag_divc.sv
// Two-stage divide/modulo by a constant: reciprocal multiply, then one
// compare-and-subtract fixup. No package dependency.
module imtag_divc #(
   parameter int XW  = 18,
   parameter int DIV = 16
) (
   input  logic                     clock,
   input  logic                     en_a,
   input  logic                     en_b,
   input  logic [XW-1:0]            x,
   output logic [XW-1:0]            q,
   output logic [$clog2(DIV)-1:0]   r
);

   localparam int RW = $clog2(DIV);
   localparam longint unsigned RECIP_L = (longint'(1) << XW) / DIV;
   localparam logic [XW-1:0] RECIP = XW'(RECIP_L);
   localparam logic [XW-1:0] DIV_V = XW'(DIV);

   logic [2*XW-1:0] prod;
   logic [XW-1:0]   qe_in;
   logic [XW-1:0]   qe_ff;
   logic [XW-1:0]   x_ff;
   logic [XW-1:0]   qd;
   logic [XW-1:0]   rem_raw;
   logic            fix;
   logic [XW-1:0]   q_in;
   logic [RW-1:0]   r_in;
   logic [XW-1:0]   q_ff;
   logic [RW-1:0]   r_ff;

   // estimate is exact or one low
   always_comb begin
      prod  = {{XW{1'b0}}, x} * {{XW{1'b0}}, RECIP};
      qe_in = prod[2*XW-1:XW];
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         x_ff  <= x;
         qe_ff <= qe_in;
      end
   end

   always_comb begin
      qd      = XW'(qe_ff * DIV_V);
      rem_raw = x_ff - qd;
      fix     = (rem_raw >= DIV_V);
      q_in    = qe_ff + XW'(fix);
      r_in    = fix ? RW'(rem_raw - DIV_V) : RW'(rem_raw);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign q = q_ff;
   assign r = r_ff;

endmodule

### verif/tb_top.sv
// Testbench for im2col_tiled_address_gen: drives im2col coordinates and
// register writes, predicts every address in a scoreboard class and checks it.
// Depends on imtag_pkg, imtag_ifs and the block's RTL.
module tb_top;
   import imtag_pkg::*;

   localparam int     CUBE_R      = 16;
   localparam int     CUBE_C      = 16;
   localparam int     NUM_REGS    = 8;
   localparam int     MAX_GAP     = 18;
   localparam int     SETTLE      = NUM_STAGES + 4;
   localparam int     RAND_PHASES = 12;
   localparam int     PHASE_ITEMS = 112;
   localparam int     MAX_REPORTS = 10;
   localparam longint TIMEOUT     = 64'd4_000_000;

   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic [KR_W-1:0] kern_row;
      logic [KR_W-1:0] kern_col;
      logic [OR_W-1:0] out_row;
      logic [OR_W-1:0] out_col;
   } coord_type;

   typedef struct packed {
      logic [DEST_W-1:0] dest_address;
      logic [SRC_W-1:0]  source_address;
      logic              is_padding;
   } addr_type;

   class addr_scoreboard;
      cfg_type  cfg;
      addr_type pending_addrs[$];
      int       mismatches;
      int       checked;
      int       padded;

      function new();
         cfg.in_height      = HW_W'(1);
         cfg.in_width       = HW_W'(1);
         cfg.kernel_height  = KH_W'(1);
         cfg.kernel_width   = KH_W'(1);
         cfg.out_width      = HW_W'(1);
         cfg.pad            = '0;
         cfg.stride         = STR_W'(1);
         cfg.tile_grid_cols = TGC_W'(1);
         mismatches = 0;
         checked    = 0;
         padded     = 0;
      endfunction

      function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
         case (idx)
            REG_IN_HEIGHT:      cfg.in_height      = data[HW_W-1:0];
            REG_IN_WIDTH:       cfg.in_width       = data[HW_W-1:0];
            REG_KERNEL_HEIGHT:  cfg.kernel_height  = data[KH_W-1:0];
            REG_KERNEL_WIDTH:   cfg.kernel_width   = data[KH_W-1:0];
            REG_OUT_WIDTH:      cfg.out_width      = data[HW_W-1:0];
            REG_PAD:            cfg.pad            = data[PAD_W-1:0];
            REG_STRIDE:         cfg.stride         = data[STR_W-1:0];
            REG_TILE_GRID_COLS: cfg.tile_grid_cols = data[TGC_W-1:0];
            default: ;
         endcase
      endfunction

      function addr_type lower_coord(coord_type c);
         longint   ch, kr, kc, orw, ocl, kh, kw, ih, iw, ow, pd, st, tgc;
         longint   mrow, mcol, tile, irow, icol, src;
         addr_type a;
         ch  = c.channel;
         kr  = c.kern_row;
         kc  = c.kern_col;
         orw = c.out_row;
         ocl = c.out_col;
         kh  = cfg.kernel_height;
         kw  = cfg.kernel_width;
         ih  = cfg.in_height;
         iw  = cfg.in_width;
         ow  = cfg.out_width;
         pd  = cfg.pad;
         st  = cfg.stride;
         tgc = cfg.tile_grid_cols;
         mrow = ch * kh * kw + kr * kw + kc;
         mcol = orw * ow + ocl;
         tile = (mrow / CUBE_R) * tgc + mcol / CUBE_C;
         a.dest_address = DEST_W'(tile * CUBE_R * CUBE_C
                                  + (mrow % CUBE_R) * CUBE_C + mcol % CUBE_C);
         irow = orw * st + kr - pd;
         icol = ocl * st + kc - pd;
         a.is_padding = !(irow >= 0 && irow < ih && icol >= 0 && icol < iw);
         src = a.is_padding ? 64'sd0 : ch * ih * iw + irow * iw + icol;
         a.source_address = SRC_W'(src);
         return a;
      endfunction

      function void note_coord(coord_type c);
         pending_addrs.push_back(lower_coord(c));
      endfunction

      function void report(string what, addr_type want, addr_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t %s: dest %h exp %h, src %h exp %h, pad %b exp %b", $time, what,
                     got.dest_address, want.dest_address, got.source_address,
                     want.source_address, got.is_padding, want.is_padding);
      endfunction

      function void check_addr(addr_type got);
         addr_type want;
         checked++;
         if (pending_addrs.size() == 0) begin
            report("item with nothing pending", '0, got);
            return;
         end
         want = pending_addrs.pop_front();
         if (want.is_padding)
            padded++;
         if (got.dest_address !== want.dest_address
             || got.source_address !== want.source_address
             || got.is_padding !== want.is_padding)
            report("address mismatch", want, got);
      endfunction
   endclass

   logic clock;
   logic reset;

   imtag_req_if req_ch ();
   imtag_rsp_if rsp_ch ();
   imtag_csr_if csr_ch ();

   im2col_tiled_address_gen #(
      .CUBE_ROWS(CUBE_R),
      .CUBE_COLS(CUBE_C)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   addr_scoreboard        sb;
   bit                    req_gaps;
   bit                    rsp_stalls;
   int                    settings;
   logic [CFG_DATA_W-1:0] cfg_words [NUM_REGS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT);
      $display("** im2col_tiled_address_gen: FAILED **");
      $finish;
   end

   function automatic coord_type coord_at(int ch, int kr, int kc, int orw, int ocl);
      coord_type c;
      c.channel  = CH_W'(ch);
      c.kern_row = KR_W'(kr);
      c.kern_col = KR_W'(kc);
      c.out_row  = OR_W'(orw);
      c.out_col  = OR_W'(ocl);
      return c;
   endfunction

   // mostly coordinates inside the current loop bounds, some full-range noise
   function automatic coord_type draw_coord(cfg_type k);
      int span, rows, cols, kh, kw;
      if ($urandom_range(0, 4) == 0)
         return coord_at($urandom_range(0, 1023), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 511),
                         $urandom_range(0, 511));
      kh   = int'(k.kernel_height);
      kw   = int'(k.kernel_width);
      span = int'(k.in_height) + 2 * int'(k.pad) - kh;
      rows = (k.stride == 0 || span < 0) ? 1 : span / int'(k.stride) + 1;
      rows = (rows > 512) ? 512 : rows;
      cols = (k.out_width == 0) ? 1 : int'(k.out_width);
      cols = (cols > 512) ? 512 : cols;
      return coord_at($urandom_range(0, 15),
                      $urandom_range(0, (kh > 0) ? kh - 1 : 0),
                      $urandom_range(0, (kw > 0) ? kw - 1 : 0),
                      $urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
   endfunction

   // random bits above the field width now and then; the block drops them
   function automatic logic [CFG_DATA_W-1:0] with_junk(int v, int w);
      logic [CFG_DATA_W-1:0] word;
      word = CFG_DATA_W'(v);
      if (w < CFG_DATA_W && $urandom_range(0, 3) == 0)
         word = word | (CFG_DATA_W'($urandom) << w);
      return word;
   endfunction

   task automatic send_coord(input coord_type c);
      int gap;
      gap = req_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.channel  = c.channel;
      req_ch.kern_row = c.kern_row;
      req_ch.kern_col = c.kern_col;
      req_ch.out_row  = c.out_row;
      req_ch.out_col  = c.out_col;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_coord(c);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.pending_addrs.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic load_config(input int ih, iw, kh, kw, ow, pd, st, tgc);
      wait_drained();
      cfg_words[REG_IN_HEIGHT]      = with_junk(ih, HW_W);
      cfg_words[REG_IN_WIDTH]       = with_junk(iw, HW_W);
      cfg_words[REG_KERNEL_HEIGHT]  = with_junk(kh, KH_W);
      cfg_words[REG_KERNEL_WIDTH]   = with_junk(kw, KH_W);
      cfg_words[REG_OUT_WIDTH]      = with_junk(ow, HW_W);
      cfg_words[REG_PAD]            = with_junk(pd, PAD_W);
      cfg_words[REG_STRIDE]         = with_junk(st, STR_W);
      cfg_words[REG_TILE_GRID_COLS] = with_junk(tgc, TGC_W);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_ch.valid = 1'b1;
         csr_ch.index = CFG_IDX_W'(i);
         csr_ch.data  = cfg_words[i];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         sb.write_reg(CFG_IDX_W'(i), cfg_words[i]);
         @(negedge clock);
      end
      csr_ch.valid = 1'b0;
      settings++;
   endtask

   task automatic load_random_config();
      int  ih, iw, kh, kw, ow, pd, st, tgc, span;
      bit  wide;
      wide = ($urandom_range(0, 5) == 0);
      ih   = wide ? $urandom_range(0, 1023) : $urandom_range(1, 64);
      iw   = wide ? $urandom_range(0, 1023) : $urandom_range(1, 64);
      kh   = wide ? $urandom_range(0, 15) : $urandom_range(1, 7);
      kw   = wide ? $urandom_range(0, 15) : $urandom_range(1, 7);
      pd   = $urandom_range(0, 7);
      st   = wide ? $urandom_range(0, 7) : $urandom_range(1, 7);
      span = iw + 2 * pd - kw;
      ow   = (wide || st == 0 || span < 0) ? $urandom_range(0, 1023) : span / st + 1;
      tgc  = wide ? $urandom_range(0, 32767) : $urandom_range(1, 64);
      load_config(ih, iw, kh, kw, ow, pd, st, tgc);
   endtask

   initial begin
      int       stall;
      addr_type got;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_stalls ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.dest_address   = rsp_ch.dest_address;
         got.source_address = rsp_ch.source_address;
         got.is_padding     = rsp_ch.is_padding;
         sb.check_addr(got);
         @(negedge clock);
      end
   end

   initial begin
      sb              = new();
      settings        = 0;
      req_gaps        = 1'b1;
      rsp_stalls      = 1'b1;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.channel  = '0;
      req_ch.kern_row = '0;
      req_ch.kern_col = '0;
      req_ch.out_row  = '0;
      req_ch.out_col  = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = REG_IN_HEIGHT;
      csr_ch.data     = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset defaults
      send_coord(coord_at(0, 0, 0, 0, 0));
      send_coord(coord_at(1023, 15, 15, 511, 511));

      // 8x8 map, 3x3 kernel, pad 1: corners, edges and indices past the kernel
      load_config(8, 8, 3, 3, 8, 1, 1, 4);
      send_coord(coord_at(0, 0, 0, 0, 0));
      send_coord(coord_at(0, 1, 1, 0, 0));
      send_coord(coord_at(5, 2, 2, 7, 7));
      send_coord(coord_at(2, 1, 1, 7, 7));
      send_coord(coord_at(3, 0, 2, 0, 3));
      send_coord(coord_at(1, 2, 0, 4, 0));
      send_coord(coord_at(1, 14, 14, 3, 3));

      // every register at its top value, both addresses wrap
      load_config(32767, 1023, 15, 15, 1023, 7, 7, 32767);
      send_coord(coord_at(1023, 15, 15, 511, 511));
      send_coord(coord_at(0, 0, 0, 0, 0));
      send_coord(coord_at(1023, 7, 7, 0, 0));
      send_coord(coord_at(1023, 15, 15, 100, 100));

      // empty map: everything is padding
      load_config(0, 5, 0, 0, 0, 0, 0, 0);
      send_coord(coord_at(0, 0, 0, 0, 0));
      send_coord(coord_at(7, 3, 1, 2, 2));
      send_coord(coord_at(1023, 15, 15, 511, 511));
      load_config(5, 0, 2, 2, 3, 1, 2, 3);
      send_coord(coord_at(1, 1, 1, 1, 1));
      send_coord(coord_at(0, 0, 0, 0, 0));

      for (int p = 0; p < RAND_PHASES; p++) begin
         load_random_config();
         req_gaps   = (p % 4 == 0) || (p % 4 == 2);
         rsp_stalls = (p % 4 == 0) || (p % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == PHASE_ITEMS / 2)
               wait_drained();
            send_coord(draw_coord(sb.cfg));
         end
      end
      wait_drained();

      $display("Checked %0d addresses (%0d padding) across %0d register settings,",
               sb.checked, sb.padded, settings);
      $display("with and without idle cycles on both channels; %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_addrs.size() == 0)
         $display("** im2col_tiled_address_gen: PASSED **");
      else
         $display("** im2col_tiled_address_gen: FAILED **");
      $finish;
   end

endmodule
